[hw/rtl/msl_pkg.sv]
package msl_pkg;

    localparam int NUM_CORES = 8;
    localparam int NUM_WAYS  = 8;
    localparam int NUM_SETS  = 256;
    localparam int ADDR_W    = 32;
    localparam int CORE_W    = 3;
    localparam int WAY_W     = 3;
    localparam int SET_W     = 8;
    localparam int TAG_W     = 30;
    localparam int AGE_W     = 3;
    localparam int FILL_W    = 4;
    localparam int ROW_AW    = CORE_W + SET_W;
    localparam int NUM_ROWS  = NUM_CORES * NUM_SETS;
    localparam int FW_W      = 5;
    localparam int CB_W      = 19;
    localparam logic [CB_W-1:0] CB_MAX = {CB_W{1'b1}};

    typedef enum logic [1:0] {
        MESI_I = 2'd0,
        MESI_S = 2'd1,
        MESI_E = 2'd2,
        MESI_M = 2'd3
    } t_mesi;

    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_STORE = 2'd1,
        FN_FLUSH = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_CORES = 2'd0,
        CFG_WAYS  = 2'd1,
        CFG_SETS  = 2'd2,
        CFG_BLOCK = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PM_INV_ALL,
        PM_DOWNGRADE,
        PM_INV_SHARED
    } t_peer_mode;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_LOCAL,
        S_LOCAL,
        S_RD_PEER,
        S_PEER,
        S_WR_LOCAL,
        S_FL_RD,
        S_FL,
        S_OUT
    } t_state;

    // one set of one core: all ways side by side
    typedef struct packed {
        logic  [NUM_WAYS-1:0][TAG_W-1:0] tag;
        t_mesi [NUM_WAYS-1:0]            mesi;
        logic  [NUM_WAYS-1:0][AGE_W-1:0] age;
        logic  [FILL_W-1:0]              fill;
    } t_row;

    typedef struct packed {
        logic              found;
        logic [WAY_W-1:0]  fway;
        logic [WAY_W-1:0]  lru;
        logic [FILL_W-1:0] mcount;
        logic [FILL_W-1:0] fill;
    } t_way_info;

endpackage

[hw/rtl/mesi_snooping_lru_cache_top.sv]
// tag and coherence state of up to eight private set-associative lru caches
// kept coherent by mesi snooping
//
// channels: input items (func, core, address) on i_in_valid / o_in_ready,
// result items on o_out_valid / i_out_ready, one result per input item.
// configuration through i_cfg_we / i_cfg_index / i_cfg_data, to be written only
// while the block is idle; the user must keep to this, the block does not enforce it.
//
// all lines live in one row memory, one row per (core, set) holding every
// way; a single row unit (tag match, lru pick, modified count) is reused
// for the local row, each peer row and each flushed row.
// a miss or a store hit on a shared line reads the local row, then reads and
// writes back each peer row in turn, then writes the local row; a hit that
// needs no snoop reads and writes only the local row; flush reads and writes
// back every configured set of each active core; an invalid func or inactive
// core is answered without the row memory. one item at a time: the row
// memory's single read and write port sets the pace. reset: a clearing pass
// zeroes the fill count of every row; no item is accepted meanwhile,
// configuration writes are taken. a stalled receiver holds the result and no
// new item is accepted until the result is taken
module mesi_snooping_lru_cache_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [2:0]  i_core,
    input  logic [31:0] i_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_hit,
    output logic        o_evicted,
    output logic        o_broadcast,
    output logic        o_peer_supplied,
    output logic [1:0]  o_line_state,
    output logic [4:0]  o_fetch_words,
    output logic [18:0] o_copy_back_words
);

    // configuration registers
    logic [3:0] r_core_count;
    logic [3:0] r_ways;
    logic [3:0] r_set_bits;
    logic [2:0] r_block_bits;

    // sequencer and item registers
    msl_pkg::t_state                 r_state, n_state;
    logic [msl_pkg::CORE_W-1:0]      r_core, n_core;
    logic [msl_pkg::SET_W-1:0]       r_set, n_set;
    logic [msl_pkg::TAG_W-1:0]       r_tag, n_tag;
    logic                            r_store, n_store;
    msl_pkg::t_peer_mode             r_mode, n_mode;
    logic [3:0]                      r_c, n_c;
    logic [msl_pkg::SET_W-1:0]       r_s, n_s;
    logic [msl_pkg::ROW_AW-1:0]      r_clr, n_clr;
    msl_pkg::t_row                   r_lrow, n_lrow;
    logic [msl_pkg::WAY_W-1:0]       r_lw, n_lw;
    logic                            r_fix, n_fix;

    // result registers
    logic                            r_hit, n_hit;
    logic                            r_evict, n_evict;
    logic                            r_bcast, n_bcast;
    logic                            r_supp, n_supp;
    msl_pkg::t_mesi                  r_lstate, n_lstate;
    logic [msl_pkg::FW_W-1:0]        r_fw, n_fw;
    logic [msl_pkg::CB_W-1:0]        r_cb, n_cb;

    // row memory
    msl_pkg::t_row                   r_mem [msl_pkg::NUM_ROWS];
    msl_pkg::t_row                   r_rdata;
    logic                            w_we;
    logic [msl_pkg::ROW_AW-1:0]      w_wa, w_ra;
    msl_pkg::t_row                   w_wd;

    // effective configuration
    logic [3:0]                      w_ncores, w_nways, w_sb;
    logic [2:0]                      w_bb;
    logic [msl_pkg::FW_W-1:0]        w_fw;
    logic [msl_pkg::SET_W-1:0]       w_set_mask, w_set;
    logic [msl_pkg::TAG_W-1:0]       w_tag;

    msl_pkg::t_way_info              w_info;
    logic                            w_need_peer;
    logic                            w_fl_last;

    function automatic msl_pkg::t_row f_mru(msl_pkg::t_row row,
                                            logic [msl_pkg::WAY_W-1:0] w,
                                            logic [msl_pkg::FILL_W-1:0] f);
        msl_pkg::t_row r;
        logic [msl_pkg::AGE_W-1:0] a;
        r = row;
        a = row.age[w];
        for (int v = 0; v < msl_pkg::NUM_WAYS; v++) begin
            if (msl_pkg::FILL_W'(v) < f && msl_pkg::WAY_W'(v) != w && row.age[v] < a) begin
                r.age[v] = row.age[v] + 1'b1;
            end
        end
        r.age[w] = '0;
        return r;
    endfunction

    function automatic logic [msl_pkg::CB_W-1:0] f_sat_add(logic [msl_pkg::CB_W-1:0] acc,
                                                           logic [7:0] v);
        logic [msl_pkg::CB_W:0] s;
        s = {1'b0, acc} + (msl_pkg::CB_W+1)'(v);
        return (s > (msl_pkg::CB_W+1)'(msl_pkg::CB_MAX)) ? msl_pkg::CB_MAX
                                                          : s[msl_pkg::CB_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_count <= 4'd1;
            r_ways       <= 4'd1;
            r_set_bits   <= 4'd8;
            r_block_bits <= 3'd4;
        end else if (i_cfg_we) begin
            case (msl_pkg::t_cfg_idx'(i_cfg_index))
                msl_pkg::CFG_CORES: r_core_count <= i_cfg_data;
                msl_pkg::CFG_WAYS:  r_ways       <= i_cfg_data;
                msl_pkg::CFG_SETS:  r_set_bits   <= i_cfg_data;
                msl_pkg::CFG_BLOCK: r_block_bits <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign w_ncores = (r_core_count == 4'd0) ? 4'd1
                    : (r_core_count > 4'd8) ? 4'd8 : r_core_count;
    assign w_nways  = (r_ways == 4'd0) ? 4'd1 : (r_ways > 4'd8) ? 4'd8 : r_ways;
    assign w_sb     = (r_set_bits > 4'd8) ? 4'd8 : r_set_bits;
    assign w_bb     = (r_block_bits < 3'd2) ? 3'd2
                    : (r_block_bits > 3'd6) ? 3'd6 : r_block_bits;
    assign w_fw       = msl_pkg::FW_W'(5'd1 << (w_bb - 3'd2));
    assign w_set_mask = msl_pkg::SET_W'((9'd1 << w_sb) - 9'd1);
    assign w_set      = msl_pkg::SET_W'(i_address >> w_bb) & w_set_mask;
    assign w_tag      = msl_pkg::TAG_W'(i_address >> (5'(w_sb) + 5'(w_bb)));

    // row memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rdata <= r_mem[w_ra];
    end

    msl_way_unit u_way (
        .i_row  (r_rdata),
        .i_tag  (r_tag),
        .o_info (w_info)
    );

    assign w_fl_last = (r_s == w_set_mask) && (r_c == w_ncores - 4'd1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            msl_pkg::S_CLEAR: begin
                if (r_clr == {msl_pkg::ROW_AW{1'b1}}) n_state = msl_pkg::S_IDLE;
            end
            msl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (msl_pkg::t_func'(i_func) == msl_pkg::FN_FLUSH) begin
                        n_state = msl_pkg::S_FL_RD;
                    end else if (msl_pkg::t_func'(i_func) == msl_pkg::FN_NONE
                                 || {1'b0, i_core} >= w_ncores) begin
                        n_state = msl_pkg::S_OUT;
                    end else begin
                        n_state = msl_pkg::S_RD_LOCAL;
                    end
                end
            end
            msl_pkg::S_RD_LOCAL: n_state = msl_pkg::S_LOCAL;
            msl_pkg::S_LOCAL: begin
                n_state = w_need_peer ? msl_pkg::S_RD_PEER : msl_pkg::S_WR_LOCAL;
            end
            msl_pkg::S_RD_PEER: begin
                if (r_c >= w_ncores)             n_state = msl_pkg::S_WR_LOCAL;
                else if (r_c != {1'b0, r_core})  n_state = msl_pkg::S_PEER;
            end
            msl_pkg::S_PEER:     n_state = msl_pkg::S_RD_PEER;
            msl_pkg::S_WR_LOCAL: n_state = msl_pkg::S_OUT;
            msl_pkg::S_FL_RD:    n_state = msl_pkg::S_FL;
            msl_pkg::S_FL: begin
                n_state = w_fl_last ? msl_pkg::S_OUT : msl_pkg::S_FL_RD;
            end
            msl_pkg::S_OUT: begin
                if (i_out_ready) n_state = msl_pkg::S_IDLE;
            end
            default: n_state = msl_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        msl_pkg::t_row row;
        logic [msl_pkg::WAY_W-1:0] lw;
        logic hit;

        n_core = r_core;   n_set = r_set;     n_tag = r_tag;    n_store = r_store;
        n_mode = r_mode;   n_c = r_c;         n_s = r_s;        n_clr = r_clr;
        n_lrow = r_lrow;   n_lw = r_lw;       n_fix = r_fix;
        n_hit = r_hit;     n_evict = r_evict; n_bcast = r_bcast;
        n_supp = r_supp;   n_lstate = r_lstate;
        n_fw = r_fw;       n_cb = r_cb;
        w_we = 1'b0;
        w_wa = r_clr;
        w_wd = '0;
        w_ra = {r_core, r_set};
        w_need_peer = 1'b0;
        row = r_rdata;
        lw  = '0;
        hit = w_info.found && r_rdata.mesi[w_info.fway] != msl_pkg::MESI_I;

        case (r_state)
            msl_pkg::S_CLEAR: begin
                w_we  = 1'b1;
                n_clr = r_clr + 1'b1;
            end
            msl_pkg::S_IDLE: begin
                n_core  = i_core;
                n_set   = w_set;
                n_tag   = w_tag;
                n_store = (msl_pkg::t_func'(i_func) == msl_pkg::FN_STORE);
                n_c = '0;     n_s = '0;
                n_hit = 1'b0; n_evict = 1'b0; n_bcast = 1'b0; n_supp = 1'b0;
                n_lstate = msl_pkg::MESI_I;
                n_fw = '0;    n_cb = '0;    n_fix = 1'b0;
            end
            msl_pkg::S_LOCAL: begin
                n_c = '0;
                if (hit) begin
                    // hit: line becomes most recent
                    row   = f_mru(r_rdata, w_info.fway, w_info.fill);
                    n_hit = 1'b1;
                    if (r_store) begin
                        if (r_rdata.mesi[w_info.fway] == msl_pkg::MESI_S) begin
                            n_bcast     = 1'b1;
                            n_mode      = msl_pkg::PM_INV_SHARED;
                            w_need_peer = 1'b1;
                        end
                        row.mesi[w_info.fway] = msl_pkg::MESI_M;
                    end
                    n_lw     = w_info.fway;
                    n_fix    = 1'b0;
                    n_lstate = row.mesi[w_info.fway];
                end else begin
                    if (w_info.found) begin
                        // tag match on an invalid line reuses that way
                        lw = w_info.fway;
                    end else if (w_info.fill < w_nways) begin
                        lw          = msl_pkg::WAY_W'(w_info.fill);
                        row.age[lw] = msl_pkg::AGE_W'(w_info.fill);
                        row.fill    = w_info.fill + 1'b1;
                    end else begin
                        lw      = w_info.lru;
                        n_evict = 1'b1;
                        if (r_rdata.mesi[lw] == msl_pkg::MESI_M) begin
                            n_cb = f_sat_add(r_cb, 8'(w_fw));
                        end
                    end
                    row.tag[lw] = r_tag;
                    row = f_mru(row, lw,
                                (row.fill > msl_pkg::FILL_W'(msl_pkg::NUM_WAYS))
                                ? msl_pkg::FILL_W'(msl_pkg::NUM_WAYS) : row.fill);
                    n_bcast     = 1'b1;
                    n_fw        = w_fw;
                    n_lw        = lw;
                    n_mode      = r_store ? msl_pkg::PM_INV_ALL : msl_pkg::PM_DOWNGRADE;
                    n_fix       = !r_store;
                    w_need_peer = 1'b1;
                    if (r_store) begin
                        row.mesi[lw] = msl_pkg::MESI_M;
                        n_lstate     = msl_pkg::MESI_M;
                    end
                end
                n_lrow = row;
            end
            msl_pkg::S_RD_PEER: begin
                w_ra = {r_c[msl_pkg::CORE_W-1:0], r_set};
                if (r_c < w_ncores && r_c == {1'b0, r_core}) n_c = r_c + 1'b1;
            end
            msl_pkg::S_PEER: begin
                if (w_info.found) begin
                    case (r_mode)
                        msl_pkg::PM_INV_ALL: row.mesi[w_info.fway] = msl_pkg::MESI_I;
                        msl_pkg::PM_DOWNGRADE: begin
                            if (r_rdata.mesi[w_info.fway] != msl_pkg::MESI_I) begin
                                n_supp = 1'b1;
                                if (r_rdata.mesi[w_info.fway] == msl_pkg::MESI_M) begin
                                    n_cb = f_sat_add(r_cb, 8'(w_fw));
                                end
                                row.mesi[w_info.fway] = msl_pkg::MESI_S;
                            end
                        end
                        msl_pkg::PM_INV_SHARED: begin
                            if (r_rdata.mesi[w_info.fway] == msl_pkg::MESI_S) begin
                                row.mesi[w_info.fway] = msl_pkg::MESI_I;
                            end
                        end
                        default: ;
                    endcase
                end
                w_we = 1'b1;
                w_wa = {r_c[msl_pkg::CORE_W-1:0], r_set};
                w_wd = row;
                n_c  = r_c + 1'b1;
            end
            msl_pkg::S_WR_LOCAL: begin
                row = r_lrow;
                if (r_fix) begin
                    // load miss: shared if a peer held a copy
                    row.mesi[r_lw] = r_supp ? msl_pkg::MESI_S : msl_pkg::MESI_E;
                    n_lstate       = row.mesi[r_lw];
                end
                w_we = 1'b1;
                w_wa = {r_core, r_set};
                w_wd = row;
            end
            msl_pkg::S_FL_RD: begin
                w_ra = {r_c[msl_pkg::CORE_W-1:0], r_s};
            end
            msl_pkg::S_FL: begin
                for (int w = 0; w < msl_pkg::NUM_WAYS; w++) begin
                    if (msl_pkg::FILL_W'(w) < w_info.fill
                        && r_rdata.mesi[w] == msl_pkg::MESI_M) begin
                        row.mesi[w] = msl_pkg::MESI_I;
                    end
                end
                n_cb = f_sat_add(r_cb, 8'(8'(w_info.mcount) << (w_bb - 3'd2)));
                w_we = 1'b1;
                w_wa = {r_c[msl_pkg::CORE_W-1:0], r_s};
                w_wd = row;
                if (r_s == w_set_mask) begin
                    n_s = '0;
                    n_c = r_c + 1'b1;
                end else begin
                    n_s = r_s + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msl_pkg::S_CLEAR;
            r_clr   <= '0;
            r_c     <= '0;
            r_s     <= '0;
            r_fix   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_c     <= n_c;
            r_s     <= n_s;
            r_fix   <= n_fix;
        end
    end

    always_ff @(posedge i_clk) begin
        r_core   <= n_core;
        r_set    <= n_set;
        r_tag    <= n_tag;
        r_store  <= n_store;
        r_mode   <= n_mode;
        r_lrow   <= n_lrow;
        r_lw     <= n_lw;
        r_hit    <= n_hit;
        r_evict  <= n_evict;
        r_bcast  <= n_bcast;
        r_supp   <= n_supp;
        r_lstate <= n_lstate;
        r_fw     <= n_fw;
        r_cb     <= n_cb;
    end

    assign o_in_ready        = (r_state == msl_pkg::S_IDLE);
    assign o_out_valid       = (r_state == msl_pkg::S_OUT);
    assign o_hit             = r_hit;
    assign o_evicted         = r_evict;
    assign o_broadcast       = r_bcast;
    assign o_peer_supplied   = r_supp;
    assign o_line_state      = r_lstate;
    assign o_fetch_words     = r_fw;
    assign o_copy_back_words = r_cb;

`ifndef ASSERT_OFF
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msl_pkg::S_CLEAR) |-> !o_in_ready)
        else $error("item accepted during clearing pass");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msl_pkg::S_IDLE || r_state == msl_pkg::S_OUT) |-> !w_we)
        else $error("row memory written while no item is at work");

    a_hit_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> (!o_evicted && o_fetch_words == '0))
        else $error("hit with eviction or fetch");

    a_evict_bcast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_evicted) |-> o_broadcast)
        else $error("eviction without bus snoop");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != msl_pkg::S_IDLE))
        else $error("accepted item did not start");
`endif

endmodule

[hw/rtl/msl_way_unit.sv]
module msl_way_unit (
    input  msl_pkg::t_row                   i_row,
    input  logic [msl_pkg::TAG_W-1:0]       i_tag,
    output msl_pkg::t_way_info              o_info
);

    logic [msl_pkg::FILL_W-1:0] w_fill;

    // clamp the fill count to the number of ways
    assign w_fill = (i_row.fill > msl_pkg::FILL_W'(msl_pkg::NUM_WAYS))
                  ? msl_pkg::FILL_W'(msl_pkg::NUM_WAYS) : i_row.fill;

    always_comb begin
        o_info        = '0;
        o_info.fill   = w_fill;
        // lowest matching way wins
        for (int w = msl_pkg::NUM_WAYS - 1; w >= 0; w--) begin
            if (msl_pkg::FILL_W'(w) < w_fill && i_row.tag[w] == i_tag) begin
                o_info.found = 1'b1;
                o_info.fway  = msl_pkg::WAY_W'(w);
            end
        end
        // oldest way, first one on ties
        for (int w = 1; w < msl_pkg::NUM_WAYS; w++) begin
            if (msl_pkg::FILL_W'(w) < w_fill && i_row.age[w] > i_row.age[o_info.lru]) begin
                o_info.lru = msl_pkg::WAY_W'(w);
            end
        end
        for (int w = 0; w < msl_pkg::NUM_WAYS; w++) begin
            if (msl_pkg::FILL_W'(w) < w_fill && i_row.mesi[w] == msl_pkg::MESI_M) begin
                o_info.mcount = o_info.mcount + 1'b1;
            end
        end
    end

endmodule
